// ----- src/ring_fifo_with_overwrite_assert.svh -----
// Assertion macros for the overwrite ring FIFO.
`ifndef RING_FIFO_WITH_OVERWRITE_ASSERT_SVH
`define RING_FIFO_WITH_OVERWRITE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RFO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rfo assertion failed");
// next-cycle implication
`define RFO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rfo assertion failed");
`else
`define RFO_ASSERT_NOW(label, ante, cons)
`define RFO_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/rfo_pkg.sv -----
// Shared types and constants for the overwrite ring FIFO.
`timescale 1ns / 1ps

package rfo_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int BYTE_W        = 8;
    localparam int FILL_W        = 7;
    localparam int POS_W         = 6;

    typedef enum logic [1:0] {
        MODE_PUSH     = 2'd0,
        MODE_POP      = 2'd1,
        MODE_PEEK_POS = 2'd2,
        MODE_PEEK_NEW = 2'd3
    } t_mode;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic              shift;
        logic              wr;
        logic [BYTE_W-1:0] din;
    } t_cell_ctl;

    // result item, lowest field last so it packs straight into tdata
    typedef struct packed {
        logic              is_empty;
        logic              is_full;
        logic [FILL_W-1:0] fill_level;
        logic [BYTE_W-1:0] data_out;
        logic              ok;
    } t_result;

endpackage

// ----- src/rfo_cell.sv -----
// One storage cell of the FIFO chain: holds one byte and one read-bus stage.
`timescale 1ns / 1ps

module rfo_cell #(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  rfo_pkg::t_cell_ctl        i_ctl,
    input  logic [AW-1:0]             i_wr_idx,
    input  logic [AW-1:0]             i_rd_idx,
    input  logic [rfo_pkg::BYTE_W-1:0] i_up_data,
    input  logic [rfo_pkg::BYTE_W-1:0] i_up_bus,
    output logic [rfo_pkg::BYTE_W-1:0] o_data,
    output logic [rfo_pkg::BYTE_W-1:0] o_bus
);
    import rfo_pkg::*;

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] r_bus;

    // shift toward the oldest end, or take the pushed byte at the write slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_up_data;
        end else if (i_ctl.wr && (i_wr_idx == AW'(IDX))) begin
            r_data <= i_ctl.din;
        end
    end

    // read bus flows down toward cell 0; the addressed cell injects its byte
    always_ff @(posedge i_clk) begin
        if (i_rd_idx == AW'(IDX)) begin
            r_bus <= r_data;
        end else begin
            r_bus <= i_up_bus;
        end
    end

    assign o_data = r_data;
    assign o_bus  = r_bus;

endmodule

// ----- src/rfo_chain.sv -----
// Row of storage cells; cell 0 holds the oldest entry.
`timescale 1ns / 1ps

module rfo_chain #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  rfo_pkg::t_cell_ctl         i_ctl,
    input  logic [AW-1:0]              i_wr_idx,
    input  logic [AW-1:0]              i_rd_idx,
    output logic [rfo_pkg::BYTE_W-1:0] o_head_data,
    output logic [rfo_pkg::BYTE_W-1:0] o_bus
);
    import rfo_pkg::*;

    logic [BYTE_W-1:0] w_data [DEPTH];
    logic [BYTE_W-1:0] w_bus  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [BYTE_W-1:0] w_up_data;
        logic [BYTE_W-1:0] w_up_bus;

        // top cell takes the pushed byte on an overwrite shift
        if (g == DEPTH - 1) begin : g_top
            assign w_up_data = i_ctl.din;
            assign w_up_bus  = '0;
        end else begin : g_mid
            assign w_up_data = w_data[g+1];
            assign w_up_bus  = w_bus[g+1];
        end

        rfo_cell #(
            .AW  (AW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_wr_idx  (i_wr_idx),
            .i_rd_idx  (i_rd_idx),
            .i_up_data (w_up_data),
            .i_up_bus  (w_up_bus),
            .o_data    (w_data[g]),
            .o_bus     (w_bus[g])
        );
    end

    assign o_head_data = w_data[0];
    assign o_bus       = w_bus[0];

endmodule

// ----- src/rfo_outq.sv -----
// Two-entry result queue in front of the output stream.
`timescale 1ns / 1ps

module rfo_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfo_pkg::t_result i_item,
    output logic             o_has_room,
    output logic             o_valid,
    output rfo_pkg::t_result o_item,
    input  logic             i_ready
);
    import rfo_pkg::*;

    t_result    r_slot [2];
    logic       r_head;
    logic [1:0] r_cnt;
    logic       n_head;
    logic [1:0] n_cnt;
    logic       w_pop;
    logic       w_wslot;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_has_room = (r_cnt != 2'd2);
    assign o_item     = r_slot[r_head];
    assign w_pop      = o_valid && i_ready;
    assign w_wslot    = r_head ^ r_cnt[0];

    always_comb begin
        n_head = r_head ^ w_pop;
        n_cnt  = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[w_wslot] <= i_item;
        end
    end

endmodule

// ----- src/ring_fifo_with_overwrite.sv -----
// Top level of the byte FIFO with optional overwrite of the oldest entry.
`timescale 1ns / 1ps

// Byte FIFO of DEPTH entries built as a row of cells, cell 0 always holding
// the oldest byte. A request item carries a mode: push, pop oldest, peek at a
// position counted from the oldest, or peek at the newest byte. Each request
// gives exactly one result item with ok, data, fill level, full and empty.
// Push and pop finish in the cycle the item is accepted (pop shifts the whole
// row one cell toward the head) and their result is registered in the output
// queue, so these run at one item per clock while results are drained. A
// successful peek walks a read bus down the cell row one cell per clock: a
// peek at position p holds the request side off while a walk counter steps up
// to p, then a finish state takes the byte at the bus head as its result; a
// peek at the newest entry counts as position fill level - 1. A refused peek
// finishes at once. Results leave through a two-entry queue, so a new request
// is taken while an earlier result still waits. With overwrite mode set, a
// push into a full FIFO drops the oldest byte and succeeds; otherwise it is
// refused. Fill level is reported modulo 128. Bytes of slots never written are
// never returned.
// Write the mode register only while idle.
module ring_fifo_with_overwrite #(
    parameter int DEPTH = rfo_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: overwrite_when_full
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // mode[1:0], data_in[9:2], position[15:10]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // ok[0], data_out[8:1], fill_level[15:9],
                                       // is_full[16], is_empty[17], zero pad
);
    import rfo_pkg::*;
    `include "ring_fifo_with_overwrite_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (POS_W > CW) ? POS_W : CW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,   // read bus travelling toward cell 0
        ST_FIN  = 3'b100    // bus head holds the peeked byte
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_tgt, n_tgt;
    logic [AW-1:0] r_walk, n_walk;
    logic        r_ovw;

    t_mode       w_mode;
    logic [BYTE_W-1:0] w_din;
    logic [POS_W-1:0]  w_pos;
    logic        w_acc;
    logic        w_full;
    logic        w_empty;
    logic        w_room;
    logic        w_push_ok;
    t_cell_ctl   w_ctl;
    logic [AW-1:0] w_wr_idx;
    logic [BYTE_W-1:0] w_head_data;
    logic [BYTE_W-1:0] w_bus;
    logic        w_q_push;
    t_result     w_res;
    t_result     w_out;

    assign w_mode  = t_mode'(s_axis_tdata[1:0]);
    assign w_din   = s_axis_tdata[9:2];
    assign w_pos   = s_axis_tdata[15:10];
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_wr_idx = AW'(r_count);
    assign w_push_ok = w_acc && (w_mode == MODE_PUSH) && !w_full;

    assign s_axis_tready = (r_state == ST_IDLE) && w_room;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_tgt     = r_tgt;
        n_walk    = r_walk;
        w_ctl     = '{shift: 1'b0, wr: 1'b0, din: w_din};
        w_q_push  = 1'b0;
        w_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    w_q_push = 1'b1;
                    case (w_mode)
                        MODE_PUSH: begin
                            if (!w_full) begin
                                w_ctl.wr   = 1'b1;
                                n_count    = r_count + CW'(1);
                                w_res.ok   = 1'b1;
                            end else if (r_ovw) begin
                                // drop oldest, new byte lands in the top cell
                                w_ctl.shift = 1'b1;
                                w_res.ok    = 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (!w_empty) begin
                                w_ctl.shift    = 1'b1;
                                n_count        = r_count - CW'(1);
                                w_res.ok       = 1'b1;
                                w_res.data_out = w_head_data;
                            end
                        end
                        MODE_PEEK_POS: begin
                            if (PW'(w_pos) < PW'(r_count)) begin
                                w_q_push = 1'b0;
                                n_tgt    = AW'(w_pos);
                                n_walk   = '0;
                                n_state  = ST_WALK;
                            end
                        end
                        MODE_PEEK_NEW: begin
                            if (!w_empty) begin
                                w_q_push = 1'b0;
                                n_tgt    = AW'(r_count - CW'(1));
                                n_walk   = '0;
                                n_state  = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_walk == r_tgt) begin
                    n_state = ST_FIN;
                end else begin
                    n_walk = r_walk + AW'(1);
                end
            end
            ST_FIN: begin
                w_q_push       = 1'b1;
                w_res.ok       = 1'b1;
                w_res.data_out = w_bus;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        w_res.fill_level = FILL_W'(n_count);
        w_res.is_full    = (n_count == CW'(DEPTH));
        w_res.is_empty   = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovw   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_ovw <= i_cfg_data;
            end
        end
    end

    // peek address and walk counter
    always_ff @(posedge i_clk) begin
        r_tgt  <= n_tgt;
        r_walk <= n_walk;
    end

    rfo_chain #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_wr_idx    (w_wr_idx),
        .i_rd_idx    (r_tgt),
        .o_head_data (w_head_data),
        .o_bus       (w_bus)
    );

    rfo_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_q_push),
        .i_item     (w_res),
        .o_has_room (w_room),
        .o_valid    (m_axis_tvalid),
        .o_item     (w_out),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, w_out};

    `RFO_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `RFO_ASSERT_NEXT(a_push_grows, w_push_ok, r_count == CW'($past(r_count) + CW'(1)))
    `RFO_ASSERT_NEXT(a_walk_holds, r_state == ST_WALK, $stable(r_count))
    `RFO_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tdata[16] && m_axis_tdata[17]))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the overwrite ring FIFO: directed table, then random bursts.
`timescale 1ns / 1ps

module testbench;
    import rfo_pkg::*;

    localparam int FIFO_DEPTH   = DEPTH_DEFAULT;
    localparam int PHASE_ITEMS  = 130;   // random items per phase
    localparam int STALL_LIMIT  = 3000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES = 100;   // margin at the end; the longest peek walks the whole row

    // one row of the directed table
    typedef struct {
        t_mode       mode;
        logic [7:0]  din;
        logic [5:0]  pos;
        logic        typed;    // 1: expected result is written in the row itself
        t_result     exp;
    } t_row;

    // burst shapes for the random part
    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } t_burst;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;

    // typed expectation travelling alongside the request item on the bus
    logic        req_typed     = 1'b0;
    t_result     req_typed_res = '0;

    // idling controls, changed only between phases
    int          tx_gap_pct    = 0;
    int          rx_stall_pct  = 0;

    int          error_count   = 0;
    int          quiet_cycles  = 0;

    // FIFO mirror: ring of bytes, pointers, count and the overwrite mode
    logic [7:0]  mirror_bytes [FIFO_DEPTH];
    int          mirror_wr;
    int          mirror_rd;
    int          mirror_count;
    logic        mirror_overwrite;

    t_result     awaited_results [$];
    t_row        directed_rows [$];

    ring_fifo_with_overwrite #(
        .DEPTH(FIFO_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Applies one request to the mirror and returns the result the block must give.
    function automatic t_result apply_fifo_request(t_mode mode, logic [7:0] din,
                                                   logic [5:0] pos);
        t_result r;
        logic    full;
        r = '0;
        full = (mirror_count == FIFO_DEPTH);
        case (mode)
            MODE_PUSH: begin
                if (!full || mirror_overwrite) begin
                    // overwrite: the oldest byte goes first
                    if (full) begin
                        mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
                        mirror_count--;
                    end
                    mirror_bytes[mirror_wr] = din;
                    mirror_wr = (mirror_wr + 1) % FIFO_DEPTH;
                    mirror_count++;
                    r.ok = 1'b1;
                end
            end
            MODE_POP: begin
                if (mirror_count != 0) begin
                    r.data_out = mirror_bytes[mirror_rd];
                    mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
                    mirror_count--;
                    r.ok = 1'b1;
                end
            end
            MODE_PEEK_POS: begin
                if (int'(pos) < mirror_count) begin
                    r.data_out = mirror_bytes[(mirror_rd + int'(pos)) % FIFO_DEPTH];
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (mirror_count != 0) begin
                    r.data_out = mirror_bytes[(mirror_rd + mirror_count - 1) % FIFO_DEPTH];
                    r.ok = 1'b1;
                end
            end
        endcase
        r.fill_level = mirror_count[6:0];
        r.is_full    = (mirror_count == FIFO_DEPTH);
        r.is_empty   = (mirror_count == 0);
        return r;
    endfunction

    function automatic t_result result_of(logic ok, logic [7:0] data, int fill);
        t_result r;
        r.ok         = ok;
        r.data_out   = data;
        r.fill_level = fill[6:0];
        r.is_full    = (fill == FIFO_DEPTH);
        r.is_empty   = (fill == 0);
        return r;
    endfunction

    task automatic compare_field(string name, int exp, int act);
        if (exp != act) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
            error_count++;
        end
    endtask

    // Monitor: mirror update on every accepted request or mode write, result check
    // on every accepted result, and the receiver's ready. Prediction runs before the
    // check so that order holds even if a result left in the cycle of its request.
    always @(posedge i_clk) begin
        t_result exp;
        t_result act;
        t_result pred;
        if (!i_rst_n) begin
            mirror_wr        = 0;
            mirror_rd        = 0;
            mirror_count     = 0;
            mirror_overwrite = 1'b0;
            awaited_results.delete();
            m_axis_tready   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                mirror_overwrite = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                pred = apply_fifo_request(t_mode'(s_axis_tdata[1:0]), s_axis_tdata[9:2],
                                          s_axis_tdata[15:10]);
                // rows with a written-out result are checked against that instead
                awaited_results.push_back(req_typed ? req_typed_res : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                act = t_result'(m_axis_tdata[17:0]);
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing expected, got %0h", $time, act);
                    error_count++;
                end else begin
                    exp = awaited_results.pop_front();
                    compare_field("ok", exp.ok, act.ok);
                    compare_field("data_out", exp.data_out, act.data_out);
                    compare_field("fill_level", exp.fill_level, act.fill_level);
                    compare_field("is_full", exp.is_full, act.is_full);
                    compare_field("is_empty", exp.is_empty, act.is_empty);
                end
            end
            m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: counts cycles in which nothing moves on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request item, with random gaps ahead of it, and waits for acceptance.
    task automatic send_request(t_mode mode, logic [7:0] din, logic [5:0] pos,
                                logic typed, t_result exp);
        while ((tx_gap_pct != 0) && ($urandom_range(0, 99) < tx_gap_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, din, mode};
        req_typed     <= typed;
        req_typed_res <= exp;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Waits until every result is in and the block has come to rest.
    // The first edge lets the monitor log the last accepted request.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_overwrite(logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(t_mode mode, logic [7:0] din, logic [5:0] pos,
                           logic typed, t_result exp);
        t_row r;
        r.mode  = mode;
        r.din   = din;
        r.pos   = pos;
        r.typed = typed;
        r.exp   = exp;
        directed_rows.push_back(r);
    endtask

    initial begin
        t_burst     burst;
        t_mode      mode;
        int         burst_len;
        int         sent;
        int         pick;
        logic [5:0] pos;

        // empty FIFO: every read is refused
        add_row(MODE_POP,      8'h00, 6'd0,  1'b1, result_of(1'b0, 8'h00, 0));
        add_row(MODE_PEEK_NEW, 8'h00, 6'd0,  1'b1, result_of(1'b0, 8'h00, 0));
        add_row(MODE_PEEK_POS, 8'hFF, 6'd0,  1'b1, result_of(1'b0, 8'h00, 0));
        add_row(MODE_PEEK_POS, 8'h00, 6'd63, 1'b1, result_of(1'b0, 8'h00, 0));
        // byte extremes in, then read back by position and as newest
        add_row(MODE_PUSH,     8'h00, 6'd63, 1'b1, result_of(1'b1, 8'h00, 1));
        add_row(MODE_PUSH,     8'hFF, 6'd0,  1'b1, result_of(1'b1, 8'h00, 2));
        add_row(MODE_PEEK_POS, 8'h00, 6'd0,  1'b1, result_of(1'b1, 8'h00, 2));
        add_row(MODE_PEEK_POS, 8'h00, 6'd1,  1'b1, result_of(1'b1, 8'hFF, 2));
        add_row(MODE_PEEK_POS, 8'h00, 6'd2,  1'b1, result_of(1'b0, 8'h00, 2));
        add_row(MODE_PEEK_NEW, 8'h00, 6'd0,  1'b1, result_of(1'b1, 8'hFF, 2));
        add_row(MODE_PUSH,     8'hA5, 6'd21, 1'b0, '0);
        add_row(MODE_PUSH,     8'h5A, 6'd42, 1'b0, '0);
        add_row(MODE_PEEK_POS, 8'h00, 6'd63, 1'b1, result_of(1'b0, 8'h00, 4));
        add_row(MODE_POP,      8'h00, 6'd0,  1'b1, result_of(1'b1, 8'h00, 3));
        add_row(MODE_POP,      8'h00, 6'd0,  1'b1, result_of(1'b1, 8'hFF, 2));
        add_row(MODE_PEEK_POS, 8'h00, 6'd1,  1'b0, '0);
        add_row(MODE_POP,      8'h00, 6'd0,  1'b0, '0);
        add_row(MODE_POP,      8'h00, 6'd0,  1'b0, '0);
        // drained again: pop on empty is refused
        add_row(MODE_POP,      8'h00, 6'd0,  1'b1, result_of(1'b0, 8'h00, 0));
        add_row(MODE_PUSH,     8'h80, 6'd0,  1'b0, '0);
        add_row(MODE_PEEK_NEW, 8'h00, 6'd0,  1'b0, '0);
        add_row(MODE_PEEK_POS, 8'h00, 6'd0,  1'b0, '0);
        add_row(MODE_POP,      8'h00, 6'd0,  1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_overwrite(1'b0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].din, directed_rows[i].pos,
                         directed_rows[i].typed, directed_rows[i].exp);

        // Random phases: overwrite alternates, idling walks through none, sender gaps,
        // receiver stalls and both. Fill bursts push past full so that refusal and
        // overwrite are both hit; drain bursts run the FIFO dry.
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            write_overwrite(phase[0] ? 1'b0 : 1'b1);
            case (phase % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 67; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 67; end
                default: begin tx_gap_pct = 27; rx_stall_pct = 27; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 2);
                burst = (pick == 0) ? BURST_FILL : (pick == 1) ? BURST_DRAIN : BURST_MIXED;
                burst_len = (burst == BURST_FILL) ? $urandom_range(60, 100)
                                                  : $urandom_range(20, 60);
                for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
                    pick = $urandom_range(0, 99);
                    case (burst)
                        BURST_FILL:
                            mode = (pick < 90) ? MODE_PUSH :
                                   (pick < 96) ? MODE_PEEK_POS : MODE_PEEK_NEW;
                        BURST_DRAIN:
                            mode = (pick < 75) ? MODE_POP  : (pick < 85) ? MODE_PUSH :
                                   (pick < 93) ? MODE_PEEK_POS : MODE_PEEK_NEW;
                        default:
                            mode = t_mode'(2'(pick % 4));
                    endcase
                    // lean peeks toward stored entries; the mirror count is only a hint
                    if ($urandom_range(0, 1) == 0 || mirror_count == 0)
                        pos = 6'($urandom_range(0, 63));
                    else
                        pos = 6'($urandom_range(0, mirror_count - 1));
                    send_request(mode, 8'($urandom_range(0, 255)), pos, 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
